/* rtl/cubic_hermite_curve_points_unit_assert.svh */
// assertion macros for cubic_hermite_curve_points_unit.sv
`ifndef CUBIC_HERMITE_CURVE_POINTS_UNIT_ASSERT_SVH
`define CUBIC_HERMITE_CURVE_POINTS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every clock edge out of reset
`define CHCP_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CHCP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`else

`define CHCP_ASSERT_ALWAYS(lbl, cond, msg)
`define CHCP_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

/* rtl/chcp_pkg.sv */
package chcp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int T_W       = 17;   // t, t^2, t^3 in unsigned q1.16
   localparam int W_W       = 21;   // signed basis weights
   localparam int ACC_W     = 56;   // product and accumulator width
   localparam int DATA_W    = 32;
   localparam int COORD_N   = 3;
   localparam int TERM_N    = 4;

   localparam logic [T_W-1:0]          ONE_Q16    = T_W'(65536);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

   // issue counter holds {coordinate, term}
   localparam logic [3:0] ISSUE_LAST = {2'd2, 2'd3};
   localparam logic [1:0] TERM_FIRST = 2'd0;
   localparam logic [1:0] TERM_LAST  = 2'd3;
   localparam logic [1:0] COORD_LAST = 2'd2;

   localparam int            PADDR_W           = 3;
   localparam logic [2:0]    ADDR_POINT_COUNT  = 3'd0;
   localparam logic [6:0]    POINT_COUNT_RESET = 7'd20;
   localparam logic [6:0]    POINT_COUNT_MIN   = 7'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RECIP,
      S_SQ,
      S_CU,
      S_WT,
      S_MAC,
      S_DRAIN,
      S_OUT
   } chcp_state_type;

   // control that travels with an operand pair through the multiplier
   typedef struct packed {
      logic accum;   // add the product into the accumulator
      logic clear;   // restart the accumulator at the rounding offset
      logic done;    // last term of a coordinate, emit the saturated sum
   } chcp_mac_op_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
   } chcp_mac_res_type;

endpackage

/* rtl/cubic_hermite_curve_points_unit.sv */
// cubic hermite curve point generator: each accepted segment (start point, start tangent,
// end point, end tangent, signed q16.16) yields n points at t = floor(i*65536/(n-1)),
// n being point_count clamped to 3..MAX_POINTS, blended with the hermite basis, rounded half up
// to q16.16 and saturated; the final point carries last_point. all multiplies run on one
// 32x32 multiplier with an accumulator. per segment a bit-serial divide forms 65536/(n-1)
// once, then per point one multiply each for t^2 and t^3, a weight step, twelve
// multiply-accumulate issues, a drain of the coordinate sums and the hand-off of the point
// to the output register; after the last point the block returns to idle, where the next
// transfer is taken. req_stall stays high from the accepted transfer until the last point
// has been loaded into the output register, and a stalled output holds the block in its
// hand-off step
`include "cubic_hermite_curve_points_unit_assert.svh"

module cubic_hermite_curve_points_unit import chcp_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   output logic                      pready,
   // segment input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [DATA_W-1:0]  req_start_x,
   input  logic signed [DATA_W-1:0]  req_start_y,
   input  logic signed [DATA_W-1:0]  req_start_z,
   input  logic signed [DATA_W-1:0]  req_start_tan_x,
   input  logic signed [DATA_W-1:0]  req_start_tan_y,
   input  logic signed [DATA_W-1:0]  req_start_tan_z,
   input  logic signed [DATA_W-1:0]  req_end_x,
   input  logic signed [DATA_W-1:0]  req_end_y,
   input  logic signed [DATA_W-1:0]  req_end_z,
   input  logic signed [DATA_W-1:0]  req_end_tan_x,
   input  logic signed [DATA_W-1:0]  req_end_tan_y,
   input  logic signed [DATA_W-1:0]  req_end_tan_z,
   // curve point output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_point_x,
   output logic signed [DATA_W-1:0]  rsp_point_y,
   output logic signed [DATA_W-1:0]  rsp_point_z,
   output logic                      rsp_last_point
);

   // point index and segment divisor (n-1) share this width
   localparam int DW = $clog2(MAX_POINTS);

   chcp_state_type state_ff, state_in;

   // configuration
   logic [6:0] point_count_ff, point_count_in;
   logic       csr_wr;
   logic       csr_hit;
   logic [6:0] n_eff;
   logic [DW-1:0] d_eff;

   // segment operands, [term][coordinate], terms p0, m0, p1, m1
   logic signed [DATA_W-1:0] vec_ff [TERM_N][COORD_N];

   logic [DW-1:0]  d_ff;
   logic [DW-1:0]  i_ff;
   logic [T_W-1:0] t_ff, t_in;
   logic [DW-1:0]  tr_ff, tr_in;
   logic [T_W-1:0] t2_ff;
   logic signed [W_W-1:0] h_ff [TERM_N];
   logic signed [W_W-1:0] h_in [TERM_N];
   logic [3:0]     iss_ff;
   logic [1:0]     res_cnt_ff;
   logic signed [DATA_W-1:0] pt_ff [COORD_N];

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                     rsp_last_ff;

   // sequencer outputs
   logic                     req_accept;
   logic                     div_start;
   logic                     out_free;
   logic                     out_load;
   logic                     is_last;
   chcp_mac_op_type          mac_op;
   logic signed [DATA_W-1:0] mac_a, mac_b;

   // shared units
   logic                     div_done;
   logic [T_W-1:0]           div_quo;
   logic [DW-1:0]            div_rem;
   logic signed [ACC_W-1:0]  mac_prod;
   chcp_mac_res_type         mac_res;

   // incremental t stepping
   logic [DW:0]    r_sum;
   logic           r_wrap;
   logic [DW:0]    r_sub;

   // basis weight terms
   logic [T_W-1:0]        t3;
   logic signed [W_W-1:0] tw, t2w, t3w;

   logic [1:0] iss_term, iss_coord;

   //--------------------------------------------------------------------
   // configuration register
   //--------------------------------------------------------------------
   assign csr_wr = psel & penable & pwrite & pready;
   assign pready = 1'b1;
   // word decode, byte offsets inside the word are ignored
   assign csr_hit = (paddr[PADDR_W-1:2] == ADDR_POINT_COUNT[PADDR_W-1:2]);

   always_comb begin
      point_count_in = point_count_ff;
      if (csr_wr && csr_hit) begin
         point_count_in = pwdata[6:0];
      end
   end

   assign prdata = csr_hit ? {{(DATA_W-7){1'b0}}, point_count_ff} : '0;

   // register keeps the raw value, clamping happens when a segment starts
   always_comb begin
      priority if (point_count_ff < POINT_COUNT_MIN) begin
         n_eff = POINT_COUNT_MIN;
      end else if (point_count_ff > 7'(MAX_POINTS)) begin
         n_eff = 7'(MAX_POINTS);
      end else begin
         n_eff = point_count_ff;
      end
   end
   assign d_eff = DW'(n_eff - 7'd1);

   //--------------------------------------------------------------------
   // shared units
   //--------------------------------------------------------------------
   // quotient and remainder of 65536/(n-1) hold until the next segment
   chcp_div #(.DW(DW)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (d_ff),
      .done    (div_done),
      .quo     (div_quo),
      .rem     (div_rem)
   );

   chcp_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .a     (mac_a),
      .b     (mac_b),
      .prod  (mac_prod),
      .res   (mac_res)
   );

   //--------------------------------------------------------------------
   // datapath helpers
   //--------------------------------------------------------------------
   assign iss_term  = iss_ff[1:0];
   assign iss_coord = iss_ff[3:2];
   assign is_last   = (i_ff == d_ff);

   // t(i+1) = t(i) + q, plus one when the remainders wrap past the divisor
   assign r_sum  = {1'b0, tr_ff} + {1'b0, div_rem};
   assign r_wrap = (r_sum >= {1'b0, d_ff});
   assign r_sub  = r_sum - {1'b0, d_ff};
   assign tr_in  = r_wrap ? r_sub[DW-1:0] : r_sum[DW-1:0];
   assign t_in   = t_ff + div_quo + T_W'(r_wrap);

   // t^3 comes straight from the product register in the weight cycle
   assign t3  = mac_prod[FRAC_BITS+T_W-1:FRAC_BITS];
   assign tw  = signed'({{(W_W-T_W){1'b0}}, t_ff});
   assign t2w = signed'({{(W_W-T_W){1'b0}}, t2_ff});
   assign t3w = signed'({{(W_W-T_W){1'b0}}, t3});

   always_comb begin
      h_in[0] = (t3w <<< 1) - (t2w + (t2w <<< 1)) + signed'({{(W_W-T_W){1'b0}}, ONE_Q16});
      h_in[1] = t3w - (t2w <<< 1) + tw;
      h_in[2] = (t2w + (t2w <<< 1)) - (t3w <<< 1);
      h_in[3] = t3w - t2w;
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   //--------------------------------------------------------------------
   // sequencer: next state
   //--------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RECIP;
            end
         end
         S_RECIP: begin
            if (div_done) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            state_in = S_CU;
         end
         S_CU: begin
            state_in = S_WT;
         end
         S_WT: begin
            state_in = S_MAC;
         end
         S_MAC: begin
            if (iss_ff == ISSUE_LAST) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (mac_res.valid && res_cnt_ff == COORD_LAST) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = is_last ? S_IDLE : S_SQ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   //--------------------------------------------------------------------
   // sequencer: outputs
   //--------------------------------------------------------------------
   always_comb begin
      req_accept = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      mac_op     = '0;
      mac_a      = '0;
      mac_b      = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_accept = req_valid;
            div_start  = req_valid;
         end
         S_RECIP: begin
         end
         S_SQ: begin
            // t * t
            mac_a = signed'({{(DATA_W-T_W){1'b0}}, t_ff});
            mac_b = signed'({{(DATA_W-T_W){1'b0}}, t_ff});
         end
         S_CU: begin
            // floor(t^2) * t
            mac_a = signed'({{(DATA_W-T_W){1'b0}}, mac_prod[FRAC_BITS+T_W-1:FRAC_BITS]});
            mac_b = signed'({{(DATA_W-T_W){1'b0}}, t_ff});
         end
         S_WT: begin
         end
         S_MAC: begin
            // weight times operand, four terms per coordinate
            mac_a        = DATA_W'(h_ff[iss_term]);
            mac_b        = vec_ff[iss_term][iss_coord];
            mac_op.accum = 1'b1;
            mac_op.clear = (iss_term == TERM_FIRST);
            mac_op.done  = (iss_term == TERM_LAST);
         end
         S_DRAIN: begin
         end
         S_OUT: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   //--------------------------------------------------------------------
   // registers
   //--------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         point_count_ff <= POINT_COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff       <= '0;
         t_ff       <= '0;
         tr_ff      <= '0;
         iss_ff     <= '0;
         res_cnt_ff <= '0;
      end else begin
         if (req_accept) begin
            i_ff  <= '0;
            t_ff  <= '0;
            tr_ff <= '0;
         end else if (out_load) begin
            i_ff  <= i_ff + DW'(1);
            t_ff  <= t_in;
            tr_ff <= tr_in;
         end
         if (state_ff == S_WT) begin
            iss_ff     <= '0;
            res_cnt_ff <= '0;
         end else begin
            if (state_ff == S_MAC) begin
               iss_ff <= iss_ff + 4'd1;
            end
            if (mac_res.valid) begin
               res_cnt_ff <= res_cnt_ff + 2'd1;
            end
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         vec_ff[0][0] <= req_start_x;
         vec_ff[0][1] <= req_start_y;
         vec_ff[0][2] <= req_start_z;
         vec_ff[1][0] <= req_start_tan_x;
         vec_ff[1][1] <= req_start_tan_y;
         vec_ff[1][2] <= req_start_tan_z;
         vec_ff[2][0] <= req_end_x;
         vec_ff[2][1] <= req_end_y;
         vec_ff[2][2] <= req_end_z;
         vec_ff[3][0] <= req_end_tan_x;
         vec_ff[3][1] <= req_end_tan_y;
         vec_ff[3][2] <= req_end_tan_z;
         d_ff         <= d_eff;
      end
      if (state_ff == S_CU) begin
         t2_ff <= mac_prod[FRAC_BITS+T_W-1:FRAC_BITS];
      end
      if (state_ff == S_WT) begin
         for (int k = 0; k < TERM_N; k++) begin
            h_ff[k] <= h_in[k];
         end
      end
      if (mac_res.valid) begin
         unique case (res_cnt_ff)
            2'd0: pt_ff[0] <= mac_res.value;
            2'd1: pt_ff[1] <= mac_res.value;
            2'd2: pt_ff[2] <= mac_res.value;
            default: begin
            end
         endcase
      end
      if (out_load) begin
         rsp_x_ff    <= pt_ff[0];
         rsp_y_ff    <= pt_ff[1];
         rsp_z_ff    <= pt_ff[2];
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_point_z    = rsp_z_ff;
   assign rsp_last_point = rsp_last_ff;

   //--------------------------------------------------------------------
   // assertions
   //--------------------------------------------------------------------
   // the stepped t must start at zero and land exactly on one
   `CHCP_ASSERT_IMPLY(a_t_first, state_ff == S_SQ && i_ff == '0, t_ff == '0, "t not zero at first point")
   `CHCP_ASSERT_IMPLY(a_t_last, state_ff == S_SQ && i_ff == d_ff, t_ff == ONE_Q16, "t not one at last point")
   // coordinate sums only come back while the blend is running
   `CHCP_ASSERT_IMPLY(a_res_window, mac_res.valid, state_ff == S_MAC || state_ff == S_DRAIN, "stray blend result")
   `CHCP_ASSERT_IMPLY(a_index_range, state_ff != S_IDLE, i_ff <= d_ff, "point index past segment end")

endmodule

/* rtl/chcp_div.sv */
// restoring divider: 65536 / divisor, one quotient bit a cycle
module chcp_div import chcp_pkg::*; #(
   parameter int DW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [T_W-1:0] quo,
   output logic [DW-1:0] rem
);

   localparam int CW = $clog2(T_W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [T_W-1:0] quo_ff, quo_in;

   logic          num_bit;
   logic [DW:0]   rem_sh;
   logic [DW:0]   rem_sub;
   logic          ge;

   // numerator is a single one at its top bit
   assign num_bit = (cnt_ff == CW'(T_W - 1));
   assign rem_sh  = {rem_ff, num_bit};
   assign ge      = (rem_sh >= {1'b0, divisor});
   assign rem_sub = rem_sh - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(T_W - 1);
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         quo_in = {quo_ff[T_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

/* rtl/chcp_mac.sv */
// shared signed multiplier with accumulator, rounding and saturation
module chcp_mac import chcp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  chcp_mac_op_type          op,
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   output logic signed [ACC_W-1:0]  prod,
   output chcp_mac_res_type         res
);

   localparam int SH_W = ACC_W - FRAC_BITS;

   logic signed [2*DATA_W-1:0] prod_full;
   logic signed [ACC_W-1:0]    prod_ff, prod_in;
   chcp_mac_op_type            tag_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SH_W-1:0]     acc_sh;
   logic signed [DATA_W-1:0]   sat;
   chcp_mac_res_type           res_ff, res_in;

   assign prod_full = a * b;
   assign prod_in   = prod_full[ACC_W-1:0];

   assign acc_in = (tag_ff.clear ? ROUND_HALF : acc_ff) + prod_ff;
   // arithmetic shift gives the floor after the half offset
   assign acc_sh = acc_in[ACC_W-1:FRAC_BITS];

   always_comb begin
      priority if (acc_sh[SH_W-1:DATA_W-1] == '0 || acc_sh[SH_W-1:DATA_W-1] == '1) begin
         sat = acc_sh[DATA_W-1:0];
      end else if (acc_sh[SH_W-1]) begin
         sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_comb begin
      res_in.valid = tag_ff.accum & tag_ff.done;
      res_in.value = sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff       <= '0;
         res_ff.valid <= 1'b0;
      end else begin
         tag_ff       <= op;
         res_ff.valid <= res_in.valid;
      end
      prod_ff <= prod_in;
      if (tag_ff.accum) begin
         acc_ff <= acc_in;
      end
      res_ff.value <= res_in.value;
   end

   assign prod = prod_ff;
   assign res  = res_ff;

endmodule

/* sim/tb_cubic_hermite_curve_points_unit.sv */
`timescale 1ns / 100ps

module tb_cubic_hermite_curve_points_unit import chcp_pkg::*; ();

   localparam int MAX_POINTS = 64;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 50;
   localparam int SMALL_PHASE_ITEMS = 16;
   localparam int LARGE_PHASE_ITEMS = 5;
   localparam int PRESSURE_ITEMS = 4;
   localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;
   localparam logic [DATA_W-1:0] Q_MAX = 32'h7fffffff;
   localparam logic [DATA_W-1:0] Q_MIN = 32'h80000000;

   // handshake timing mixes
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // one curve segment, field order matches the input ports
   typedef struct packed {
      logic signed [DATA_W-1:0] start_x;
      logic signed [DATA_W-1:0] start_y;
      logic signed [DATA_W-1:0] start_z;
      logic signed [DATA_W-1:0] start_tan_x;
      logic signed [DATA_W-1:0] start_tan_y;
      logic signed [DATA_W-1:0] start_tan_z;
      logic signed [DATA_W-1:0] end_x;
      logic signed [DATA_W-1:0] end_y;
      logic signed [DATA_W-1:0] end_z;
      logic signed [DATA_W-1:0] end_tan_x;
      logic signed [DATA_W-1:0] end_tan_y;
      logic signed [DATA_W-1:0] end_tan_z;
   } segment_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic                     last;
   } curve_point_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // configuration port
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // segment input and point output
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   segment_type              drive_seg = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_point_x;
   logic signed [DATA_W-1:0] rsp_point_y;
   logic signed [DATA_W-1:0] rsp_point_z;
   logic                     rsp_last_point;

   // bench state
   segment_type     pending_segments[$];
   curve_point_type expected_points[$];
   curve_point_type expected_head;
   logic [6:0]      cfg_point_count = POINT_COUNT_RESET;
   logic            seg_taken = 1'b0;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              segments_sent = 0;
   int              segments_predicted = 0;
   int              points_checked = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   cubic_hermite_curve_points_unit #(
      .MAX_POINTS(MAX_POINTS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_x    (drive_seg.start_x),
      .req_start_y    (drive_seg.start_y),
      .req_start_z    (drive_seg.start_z),
      .req_start_tan_x(drive_seg.start_tan_x),
      .req_start_tan_y(drive_seg.start_tan_y),
      .req_start_tan_z(drive_seg.start_tan_z),
      .req_end_x      (drive_seg.end_x),
      .req_end_y      (drive_seg.end_y),
      .req_end_z      (drive_seg.end_z),
      .req_end_tan_x  (drive_seg.end_tan_x),
      .req_end_tan_y  (drive_seg.end_tan_y),
      .req_end_tan_z  (drive_seg.end_tan_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_z    (rsp_point_z),
      .rsp_last_point (rsp_last_point)
   );

   // 10 ns clock
   always #5 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d points outstanding", cycle_count,
                  expected_points.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // one line per failure, counted for the final verdict
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // append a segment at the tail of the pending queue
   task automatic add_segment(input segment_type s);
      pending_segments.insert(pending_segments.size(), s);
   endtask

   // weighted sum of the four vectors for one coordinate, q.32 rounded half up to q16.16
   function automatic logic [DATA_W-1:0] hermite_blend(input longint h00, input longint h10,
                                                       input longint h01, input longint h11,
                                                       input logic signed [DATA_W-1:0] p0,
                                                       input logic signed [DATA_W-1:0] m0,
                                                       input logic signed [DATA_W-1:0] p1,
                                                       input logic signed [DATA_W-1:0] m1);
      longint acc;
      acc = h00 * longint'(p0) + h10 * longint'(m0) + h01 * longint'(p1) + h11 * longint'(m1);
      // arithmetic shift of a signed sum is a floor divide
      acc = (acc + 64'sd32768) >>> FRAC_BITS;
      if (acc > COORD_MAX)
         return Q_MAX;
      if (acc < COORD_MIN)
         return Q_MIN;
      return acc[DATA_W-1:0];
   endfunction

   // queue every point that one accepted segment must produce
   function automatic void predict_segment(input segment_type s);
      int unsigned     n;
      int unsigned     i;
      longint          t;
      longint          t2;
      longint          t3;
      longint          h00;
      longint          h10;
      longint          h01;
      longint          h11;
      curve_point_type pt;
      // register keeps its raw value, the block clamps the count it uses
      n = cfg_point_count;
      if (n < POINT_COUNT_MIN)
         n = POINT_COUNT_MIN;
      if (n > MAX_POINTS)
         n = MAX_POINTS;
      for (i = 0; i < n; i++) begin
         t = longint'((i << FRAC_BITS) / (n - 1));
         t2 = (t * t) >>> FRAC_BITS;
         t3 = (t2 * t) >>> FRAC_BITS;
         h00 = 2 * t3 - 3 * t2 + 65536;
         h10 = t3 - 2 * t2 + t;
         h01 = -2 * t3 + 3 * t2;
         h11 = t3 - t2;
         pt.x = hermite_blend(h00, h10, h01, h11, s.start_x, s.start_tan_x, s.end_x, s.end_tan_x);
         pt.y = hermite_blend(h00, h10, h01, h11, s.start_y, s.start_tan_y, s.end_y, s.end_tan_y);
         pt.z = hermite_blend(h00, h10, h01, h11, s.start_z, s.start_tan_z, s.end_z, s.end_tan_z);
         pt.last = (i == n - 1);
         expected_points.insert(expected_points.size(), pt);
      end
   endfunction

   // coordinate mix: mostly modest values, some full range, some extremes
   function automatic logic [DATA_W-1:0] random_coord();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50)
         return DATA_W'($urandom_range(2097152)) - 32'd1048576;
      if (pick < 85)
         return $urandom;
      case ($urandom_range(3))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic segment_type random_segment();
      logic [12*DATA_W-1:0] bits;
      for (int k = 0; k < 12; k++)
         bits[k*DATA_W +: DATA_W] = random_coord();
      return segment_type'(bits);
   endfunction

   // driver: inputs move on the falling edge only
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         // next segment only once the current one has transferred
         if (!req_valid || seg_taken) begin
            if (pending_segments.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_seg <= pending_segments.pop_front();
               req_valid <= 1'b1;
               segments_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // monitor: transfers sampled on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         seg_taken <= 1'b0;
      end else begin
         seg_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_segment(drive_seg);
            segments_predicted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("unexpected point x=%h y=%h z=%h last=%b",
                               rsp_point_x, rsp_point_y, rsp_point_z, rsp_last_point));
            end else begin
               expected_head = expected_points.pop_front();
               if (rsp_point_x !== expected_head.x)
                  report_mismatch($sformatf("point %0d x got %h want %h", points_checked,
                                  rsp_point_x, expected_head.x));
               if (rsp_point_y !== expected_head.y)
                  report_mismatch($sformatf("point %0d y got %h want %h", points_checked,
                                  rsp_point_y, expected_head.y));
               if (rsp_point_z !== expected_head.z)
                  report_mismatch($sformatf("point %0d z got %h want %h", points_checked,
                                  rsp_point_z, expected_head.z));
               if (rsp_last_point !== expected_head.last)
                  report_mismatch($sformatf("point %0d last_point got %b want %b",
                                  points_checked, rsp_last_point, expected_head.last));
               points_checked++;
            end
         end
      end
   end

   // block is idle: nothing queued, nothing in flight, nothing owed
   task automatic wait_for_drain();
      do
         @(negedge clock);
      while (pending_segments.size() != 0 || segments_sent != segments_predicted ||
             expected_points.size() != 0);
   endtask

   // one apb transfer, setup then access
   task automatic csr_access(input logic wr, input logic [PADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // register write while idle, then read the point count back
   task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      logic [DATA_W-1:0] rdata;
      wait_for_drain();
      // last point may still be leaving the output register
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_access(1'b1, addr, data, rdata);
      if (addr == ADDR_POINT_COUNT)
         cfg_point_count = data[6:0];
      csr_access(1'b0, ADDR_POINT_COUNT, '0, rdata);
      if (rdata[6:0] !== cfg_point_count)
         report_mismatch($sformatf("point_count read back %h want %h", rdata[6:0],
                         cfg_point_count));
   endtask

   // stimulus sequencer
   initial begin
      logic [DATA_W-1:0] rdata;
      segment_type       seg;
      int                phase_counts[14] = '{3, 7, 64, 4, 12, 5, 127, 9, 3, 33, 6, 2, 10, 0};
      int                phase_items;
      idle_mode_type     mode;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset value of the point count, read back before any write
      csr_access(1'b0, ADDR_POINT_COUNT, '0, rdata);
      if (rdata[6:0] !== POINT_COUNT_RESET)
         report_mismatch($sformatf("point_count after reset %h want %h", rdata[6:0],
                         POINT_COUNT_RESET));

      // directed segments at the reset count: zero, both rails, bit patterns
      add_segment(segment_type'({12{32'h00000000}}));
      add_segment(segment_type'({12{Q_MAX}}));
      add_segment(segment_type'({12{Q_MIN}}));
      add_segment(segment_type'({{3{Q_MAX}}, {3{Q_MIN}}, {3{Q_MAX}}, {3{Q_MIN}}}));
      add_segment(segment_type'({12{32'haaaaaaaa}}));
      add_segment(segment_type'({12{32'h55555555}}));
      // tiny negatives exercise the half-up rounding
      add_segment(segment_type'({12{32'hffffffff}}));

      // counts below range are used as the minimum
      write_register(ADDR_POINT_COUNT, 32'd0);
      add_segment(random_segment());
      add_segment(segment_type'({{6{Q_MIN}}, {6{Q_MAX}}}));
      write_register(ADDR_POINT_COUNT, 32'd2);
      add_segment(random_segment());
      write_register(ADDR_POINT_COUNT, 32'd3);
      add_segment(segment_type'({12{Q_MAX}}));
      add_segment(segment_type'({12{Q_MIN}}));
      // largest count, then counts above range that clamp to it
      write_register(ADDR_POINT_COUNT, 32'd64);
      add_segment(segment_type'({{3{Q_MAX}}, {3{Q_MAX}}, {3{Q_MIN}}, {3{Q_MIN}}}));
      add_segment(random_segment());
      write_register(ADDR_POINT_COUNT, 32'd65);
      add_segment(random_segment());
      write_register(ADDR_POINT_COUNT, 32'hffffffff);
      add_segment(random_segment());
      // unmapped register address must leave the point count alone
      write_register(ADDR_UNUSED, $urandom);
      add_segment(random_segment());
      write_register(ADDR_POINT_COUNT, 32'd1);
      add_segment(random_segment());

      // random phases, each with its own count and timing mix
      for (int p = 0; p < 14; p++) begin
         write_register(ADDR_POINT_COUNT, DATA_W'(phase_counts[p]));
         mode = idle_mode_type'(p % 4);
         case (mode)
            IDLE_NONE: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct = 68;
               rsp_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct = 0;
               rsp_stall_pct = 68;
            end
            default: begin
               send_idle_pct = 15;
               rsp_stall_pct = 15;
            end
         endcase
         // big counts are slow, keep those phases short
         phase_items = (phase_counts[p] >= 32) ? LARGE_PHASE_ITEMS : SMALL_PHASE_ITEMS;
         for (int k = 0; k < phase_items; k++) begin
            // first phase: for its first PRESSURE_ITEMS segments the sender holds off until every point has come back
            if (p == 0 && k < PRESSURE_ITEMS)
               wait_for_drain();
            seg = random_segment();
            add_segment(seg);
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_points.size() != 0)
         report_mismatch($sformatf("%0d points never arrived", expected_points.size()));

      $display("checked %0d segments, %0d curve points, point count swept from 0 to 127",
               segments_predicted, points_checked);
      $display("timing mixes: steady flow, sender gaps, output stalls, and both at once");
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/chcp_pkg.sv
rtl/chcp_div.sv
rtl/chcp_mac.sv
rtl/cubic_hermite_curve_points_unit.sv
sim/tb_cubic_hermite_curve_points_unit.sv
